@@ hdl/rhv_pkg.sv @@
package rhv_pkg;

	// Field widths
	localparam int unsigned HDR_BYTES_W = 16;
	localparam int unsigned CLEN_W      = 31;
	localparam int unsigned CFG_DATA_W  = 31;

	// Register indexes on the configuration port
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t CFG_MAX_HEADER_BYTES   = 1'b0;
	localparam cfg_index_t CFG_MAX_CONTENT_LENGTH = 1'b1;

	// Register reset values
	localparam logic [HDR_BYTES_W-1:0] MAX_HEADER_BYTES_RST   = 16'd8192;
	localparam logic [CLEN_W-1:0]      MAX_CONTENT_LENGTH_RST = 31'd1048576;

	// Request kinds
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// Verdict codes
	localparam logic VERDICT_OK  = 1'b0;
	localparam logic VERDICT_BAD = 1'b1;

	// One request: a header byte or the end of the connection
	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} req_t;

	// One verdict
	typedef struct packed {
		logic                   verdict;
		logic [CLEN_W-1:0]      content_length;
		logic [HDR_BYTES_W-1:0] header_bytes;
	} rsp_t;

endpackage

@@ hdl/request_header_validator.sv @@
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | rhv_pkg::req_t (req_type, data_byte)
// rsp     | out       | rsp_valid, rsp_stall | rhv_pkg::rsp_t (verdict, content_length,
//         |           |                      |   header_bytes)
// cfg     | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One request per cycle while req_stall is low. A request is registered in an input stage,
// then parser logic updates the header state and, when a verdict is due, loads the output
// register.
// arst_n clears the parser state and loads the register defaults.
// req_stall rises only while a verdict waits in the output register and rsp_stall is high.
// cfg_ready is always high.
module request_header_validator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  rhv_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output rhv_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  rhv_pkg::cfg_index_t           cfg_index,
	input  logic [rhv_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rhv_pkg::*;

	typedef enum logic [3:0] {
		PH_POST, PH_WS1, PH_SKIP1, PH_MSG, PH_WS2, PH_SKIP2, PH_VER, PH_TAIL,
		PH_NAME, PH_OTHER, PH_HOST, PH_CLLEAD, PH_CLSIGN, PH_CLDIG, PH_CLTRL
	} phase_t;

	// Per-line parser state; err survives line boundaries
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  kpos;
		logic [1:0]  cand;    // bit0 Host, bit1 Content-Length
		logic [1:0]  vflags;  // bit0 host value non-blank, bit1 minus sign
		logic [31:0] acc;
		logic        err;
	} line_t;

	localparam logic [31:0] ACC_SAT = 32'h8000_0000;
	localparam logic [7:0]  CH_CR    = 8'h0D;
	localparam logic [7:0]  CH_LF    = 8'h0A;
	localparam logic [7:0]  CH_COLON = 8'h3A;
	localparam logic [7:0]  CH_PLUS  = 8'h2B;
	localparam logic [7:0]  CH_MINUS = 8'h2D;
	localparam logic [7:0]  CH_NUL   = 8'h00;

	// Keywords, left aligned in 16 characters
	localparam logic [127:0] STR_POST = {"POST", 96'd0};
	localparam logic [127:0] STR_MSG  = {"message", 72'd0};
	localparam logic [127:0] STR_VER  = {"SIMPLE/1.0", 48'd0};
	localparam logic [127:0] STR_HOST = {"host", 96'd0};
	localparam logic [127:0] STR_CL   = {"content-length", 16'd0};
	localparam logic [3:0]   LEN_POST = 4'd4;
	localparam logic [3:0]   LEN_MSG  = 4'd7;
	localparam logic [3:0]   LEN_VER  = 4'd10;
	localparam logic [3:0]   LEN_HOST = 4'd4;
	localparam logic [3:0]   LEN_CL   = 4'd14;

	function automatic logic [7:0] ch_at(logic [127:0] s, logic [3:0] i);
		logic [3:0] r;
		r = 4'd15 - i;
		return s[{r, 3'b000} +: 8];
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	// acc * 10 + digit, saturating at 2^31
	function automatic logic [31:0] add_digit(logic [31:0] acc, logic [7:0] c);
		logic [35:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, c[3:0]};
		return (v > {4'd0, ACC_SAT}) ? ACC_SAT : v[31:0];
	endfunction

	function automatic line_t match_kw(line_t s, logic [7:0] c, logic [127:0] word,
		logic [3:0] len, phase_t nxt);
		line_t n;
		n = s;
		if (s.kpos < len && c == ch_at(word, s.kpos)) begin
			n.kpos = s.kpos + 4'd1;
			if (n.kpos == len) begin
				n.phase = nxt;
				n.kpos  = 4'd0;
			end
		end else begin
			n.err = 1'b1;
		end
		return n;
	endfunction

	function automatic line_t clear_line(line_t s, logic first);
		line_t n;
		n        = s;
		n.phase  = first ? PH_POST : PH_NAME;
		n.kpos   = 4'd0;
		n.cand   = 2'b11;
		n.vflags = 2'b00;
		n.acc    = 32'd0;
		return n;
	endfunction

	// One byte through the line parser
	function automatic line_t feed(line_t s, logic [7:0] c);
		line_t n;
		line_t m;
		n = s;
		m = s;
		m.kpos = 4'd0;
		if (!s.err) begin
			if (c == CH_NUL) begin
				n.err = 1'b1;
			end else begin
				case (s.phase)
					PH_POST: n = match_kw(s, c, STR_POST, LEN_POST, PH_WS1);
					PH_WS1: begin
						if (is_ws(c)) n.phase = PH_SKIP1;
						else n.err = 1'b1;
					end
					PH_SKIP1: begin
						if (!is_ws(c)) begin
							m.phase = PH_MSG;
							n = match_kw(m, c, STR_MSG, LEN_MSG, PH_WS2);
						end
					end
					PH_MSG: n = match_kw(s, c, STR_MSG, LEN_MSG, PH_WS2);
					PH_WS2: begin
						if (is_ws(c)) n.phase = PH_SKIP2;
						else n.err = 1'b1;
					end
					PH_SKIP2: begin
						if (!is_ws(c)) begin
							m.phase = PH_VER;
							n = match_kw(m, c, STR_VER, LEN_VER, PH_TAIL);
						end
					end
					PH_VER: n = match_kw(s, c, STR_VER, LEN_VER, PH_TAIL);
					PH_TAIL: begin
						if (!is_ws(c)) n.err = 1'b1;
					end
					PH_NAME: begin
						if (c == CH_COLON) begin
							if (s.cand[0] && s.kpos == LEN_HOST) n.phase = PH_HOST;
							else if (s.cand[1] && s.kpos == LEN_CL) n.phase = PH_CLLEAD;
							else n.phase = PH_OTHER;
						end else begin
							if (s.kpos >= LEN_HOST || to_lower(c) != ch_at(STR_HOST, s.kpos))
								n.cand[0] = 1'b0;
							if (s.kpos >= LEN_CL || to_lower(c) != ch_at(STR_CL, s.kpos))
								n.cand[1] = 1'b0;
							if (s.kpos != 4'd15) n.kpos = s.kpos + 4'd1;
						end
					end
					PH_OTHER: ;
					PH_HOST: begin
						if (!is_ws(c)) n.vflags[0] = 1'b1;
					end
					PH_CLLEAD: begin
						if (!is_ws(c)) begin
							if (c == CH_PLUS) begin
								n.phase = PH_CLSIGN;
							end else if (c == CH_MINUS) begin
								n.vflags[1] = 1'b1;
								n.phase     = PH_CLSIGN;
							end else if (is_digit(c)) begin
								n.acc   = add_digit(s.acc, c);
								n.phase = PH_CLDIG;
							end else begin
								n.err = 1'b1;
							end
						end
					end
					PH_CLSIGN: begin
						if (is_digit(c)) begin
							n.acc   = add_digit(s.acc, c);
							n.phase = PH_CLDIG;
						end else begin
							n.err = 1'b1;
						end
					end
					PH_CLDIG: begin
						if (is_digit(c)) n.acc = add_digit(s.acc, c);
						else if (is_ws(c)) n.phase = PH_CLTRL;
						else n.err = 1'b1;
					end
					PH_CLTRL: begin
						if (!is_ws(c)) n.err = 1'b1;
					end
					default: n.err = 1'b1;
				endcase
			end
		end
		return n;
	endfunction

	// Configuration registers
	logic [HDR_BYTES_W-1:0] max_hdr_q;
	logic [CLEN_W-1:0]      max_cl_q;

	// Input stage
	logic valid_s1;
	req_t req_s1;

	// Request state
	logic [HDR_BYTES_W-1:0] cnt_q;
	logic [1:0]             tp_q;
	logic                   first_q;
	line_t                  line_q;
	logic                   host_q;
	logic                   len_q;
	logic [CLEN_W-1:0]      stored_q;

	// Output register
	logic out_valid_q;
	rsp_t out_q;

	// Next state
	logic [HDR_BYTES_W-1:0] cnt_d;
	logic [1:0]             tp_d;
	logic                   first_d;
	line_t                  line_d;
	logic                   host_d;
	logic                   len_d;
	logic [CLEN_W-1:0]      stored_d;
	logic                   emit;
	rsp_t                   rsp_d;

	logic s1_go;
	logic s1_fire;
	logic [HDR_BYTES_W-1:0] cnt_inc;
	logic                   pending;
	logic                   bad;
	line_t                  ln;

	assign s1_go     = !out_valid_q || !rsp_stall;
	assign s1_fire   = valid_s1 && s1_go;
	assign req_stall = valid_s1 && !s1_go;
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign cnt_inc = cnt_q + 16'd1;
	assign pending = (tp_q == 2'd1) || (tp_q == 2'd3);

	// Parser step for the request in the input stage
	always_comb begin
		cnt_d    = cnt_q;
		tp_d     = tp_q;
		first_d  = first_q;
		line_d   = line_q;
		host_d   = host_q;
		len_d    = len_q;
		stored_d = stored_q;
		emit     = 1'b0;
		bad      = VERDICT_BAD;
		ln       = line_q;
		rsp_d.header_bytes = cnt_inc;

		if (req_s1.req_type == REQ_END) begin
			emit = 1'b1;
			rsp_d.header_bytes = cnt_q;
		end else begin
			cnt_d = cnt_inc;
			if (pending && req_s1.data_byte == CH_LF) begin
				if (tp_q == 2'd3) begin
					emit = 1'b1;
					bad  = line_q.err || !host_q || !len_q;
				end else begin
					// End of a header line
					if (!line_q.err) begin
						case (line_q.phase)
							PH_TAIL, PH_OTHER: ;
							PH_HOST: begin
								if (line_q.vflags[0]) host_d = 1'b1;
								else ln.err = 1'b1;
							end
							PH_CLDIG, PH_CLTRL: begin
								if ((line_q.vflags[1] && line_q.acc != 32'd0) ||
									line_q.acc > {1'b0, max_cl_q}) begin
									ln.err = 1'b1;
								end else begin
									stored_d = line_q.acc[CLEN_W-1:0];
									len_d    = 1'b1;
								end
							end
							default: ln.err = 1'b1;
						endcase
					end
					first_d = 1'b0;
					line_d  = clear_line(ln, 1'b0);
					tp_d    = 2'd2;
				end
			end else begin
				// A held CR that is not part of a line break counts as whitespace
				if (pending) ln = feed(line_q, CH_CR);
				if (req_s1.data_byte == CH_CR) begin
					tp_d   = (tp_q == 2'd2) ? 2'd3 : 2'd1;
					line_d = ln;
				end else begin
					line_d = feed(ln, req_s1.data_byte);
					tp_d   = 2'd0;
				end
			end
			// Byte cap, unless the terminator already closed the request
			if (!emit && cnt_inc >= max_hdr_q) emit = 1'b1;
		end

		rsp_d.verdict        = bad;
		rsp_d.content_length = (bad == VERDICT_BAD) ? '0 : stored_d;

		// A verdict starts a new request
		if (emit) begin
			cnt_d    = '0;
			tp_d     = 2'd0;
			first_d  = 1'b1;
			host_d   = 1'b0;
			len_d    = 1'b0;
			stored_d = '0;
			line_d   = clear_line('0, 1'b1);
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q <= MAX_HEADER_BYTES_RST;
			max_cl_q  <= MAX_CONTENT_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_HEADER_BYTES:   max_hdr_q <= cfg_data[HDR_BYTES_W-1:0];
				CFG_MAX_CONTENT_LENGTH: max_cl_q  <= cfg_data[CLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) req_s1 <= req;
	end

	// Request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			tp_q     <= 2'd0;
			first_q  <= 1'b1;
			line_q   <= clear_line('0, 1'b1);
			host_q   <= 1'b0;
			len_q    <= 1'b0;
			stored_q <= '0;
		end else if (s1_fire) begin
			cnt_q    <= cnt_d;
			tp_q     <= tp_d;
			first_q  <= first_d;
			line_q   <= line_d;
			host_q   <= host_d;
			len_q    <= len_d;
			stored_q <= stored_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) out_q <= rsp_d;
	end

`ifndef NO_ASSERTIONS
	// Every verdict returns the parser to the start of a request
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && emit |=> cnt_q == '0 && first_q && !host_q && !len_q && tp_q == 2'd0)
		else $error("parser state not cleared after verdict");

	// The input side backs up only behind a held verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> out_valid_q && rsp_stall)
		else $error("input stalled without a held verdict");

	// An accepted request carries both headers and a length within the limit
	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && emit && rsp_d.verdict == VERDICT_OK |->
			host_q && len_q && !line_q.err && rsp_d.content_length <= max_cl_q)
		else $error("accepted request fails header checks");

	// The length accumulator saturates
	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		line_q.acc <= ACC_SAT)
		else $error("length accumulator past saturation");

	// A rejected request reports no length
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && emit && rsp_d.verdict == VERDICT_BAD |=> out_q.content_length == '0)
		else $error("length reported on bad request");
`endif

endmodule
